// ===== rtl/rrob_pkg.sv =====
// Shared types, field widths and operation codes of the rename map and reorder buffer.
`default_nettype none

package rrob_pkg;

    localparam int REG_W       = 6;
    localparam int TAG_OUT_W   = 6;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_VAL_W   = 7;
    localparam int ENTRIES_W   = 7;
    localparam int RETW_W      = 4;
    localparam int ENTRIES_RST = 64;
    localparam int RETW_RST    = 4;

    localparam logic [FUNC_W-1:0] FUNC_RENAME   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_COMPLETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RETIRE   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_TAG = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROB_ENTRIES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETIRE_WIDTH = 2'd1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              src1_valid;
        logic [REG_W-1:0]  src1_reg;
        logic              src2_valid;
        logic [REG_W-1:0]  src2_reg;
        logic              dst_valid;
        logic [REG_W-1:0]  dst_reg;
        logic [REG_W-1:0]  complete_tag;
    } rrob_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 src1_in_rob;
        logic [TAG_OUT_W-1:0] src1_tag;
        logic                 src1_avail;
        logic                 src2_in_rob;
        logic [TAG_OUT_W-1:0] src2_tag;
        logic                 src2_avail;
        logic [TAG_OUT_W-1:0] entry_tag;
        logic                 retired_valid;
        logic                 retired_dst_valid;
        logic [REG_W-1:0]     retired_dst_reg;
        logic                 last;
    } rrob_rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_VAL_W-1:0] value;
    } rrob_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RENAME,
        ST_COMPLETE,
        ST_NOP,
        ST_RET_CHK,
        ST_RET_UPD
    } rrob_state_t;

    typedef struct packed {
        logic req_ready;
        logic accept;
        logic emit;
        logic rename_wr;
        logic complete_wr;
        logic retire_wr;
        logic ret_chk_rd;
        logic dst_rd;
    } rrob_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/rrob_ifs.sv =====
// Request, response and configuration channel interfaces.
`default_nettype none

interface rrob_req_if import rrob_pkg::*; ();
    logic      valid;
    logic      ready;
    rrob_req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rrob_rsp_if import rrob_pkg::*; ();
    logic      valid;
    logic      ready;
    rrob_rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rrob_cfg_if import rrob_pkg::*; ();
    logic      valid;
    logic      ready;
    rrob_cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/register_rename_reorder_buffer.sv =====
// Register rename map with a circular reorder buffer, top level.
//
// Requests arrive on req (valid/ready): rename, complete or retire. Results
// leave on rsp (valid/ready), one per rename, complete or unknown operation,
// and one per retired entry for a retire (a single empty result when the head
// is not retirable); the last result of a request carries last.
// cfg writes rob_entries (index 0) and retire_width (index 1); it is always
// ready and must be used only while no request is in flight.
// A rename, complete or unknown request reads the map tag RAM in the accept
// step, then resolves the lookup and writes back in its own state. A retire
// passes RET_CHK and RET_UPD once per retired entry (RET_CHK alone when none
// retires): each entry needs a destination RAM read then a map tag RAM read.
// req is accepted only while the sequencer is idle; a finished result sits in
// the output register and does not block the next accept. When rsp stalls,
// the sequencer holds in its emitting step with no state change.
// Reset empties the buffer, points every register at the architectural file,
// zeroes both pointers and loads the default configuration; no clearing pass.
`default_nettype none

module register_rename_reorder_buffer
    import rrob_pkg::*;
#(
    parameter int ROB_DEPTH  = 64,
    parameter int ARCH_REGS  = 64,
    parameter int MAX_RETIRE = 8
) (
    input  wire        clk,
    input  wire        rst_n,
    rrob_req_if.sink   req,
    rrob_rsp_if.source rsp,
    rrob_cfg_if.sink   cfg
);

    localparam int TAG_W    = $clog2(ROB_DEPTH);
    localparam int LIVE_W   = $clog2(ROB_DEPTH + 1);
    localparam int AREG_W   = $clog2(ARCH_REGS);
    localparam int RCNT_W   = $clog2(MAX_RETIRE + 1);
    localparam int AX_W     = REG_W + AREG_W;
    localparam int C_W      = REG_W + LIVE_W;
    localparam int EW       = (LIVE_W > ENTRIES_W) ? LIVE_W : ENTRIES_W;
    localparam int RW       = (RCNT_W > RETW_W) ? RCNT_W : RETW_W;
    localparam int LIVE_RST = (ROB_DEPTH < ENTRIES_RST) ? ROB_DEPTH : ENTRIES_RST;
    localparam int LIM_RST  = (MAX_RETIRE < RETW_RST) ? MAX_RETIRE : RETW_RST;

    function automatic logic [TAG_W-1:0] advance(input logic [TAG_W-1:0] p,
                                                input logic [LIVE_W-1:0] live);
        logic [LIVE_W-1:0] p1;
        p1 = LIVE_W'(p) + LIVE_W'(1);
        return (p1 >= live) ? '0 : p1[TAG_W-1:0];
    endfunction

    rrob_ctl_t ctl;

    rrob_req_t item_reg;
    rrob_rsp_t rsp_reg;
    rrob_rsp_t rsp_next;
    logic      out_valid_reg;
    logic      out_valid_next;

    logic [LIVE_W-1:0] live_reg;
    logic [LIVE_W-1:0] live_next;
    logic [RCNT_W-1:0] lim_reg;
    logic [RCNT_W-1:0] lim_next;
    logic [TAG_W-1:0]  head_reg;
    logic [TAG_W-1:0]  head_next;
    logic [TAG_W-1:0]  tail_reg;
    logic [TAG_W-1:0]  tail_next;
    logic [RCNT_W-1:0] cnt_reg;
    logic [RCNT_W-1:0] cnt_next;

    logic [ARCH_REGS-1:0] map_in_rob_reg;
    logic [ARCH_REGS-1:0] map_in_rob_next;
    logic [ROB_DEPTH-1:0] rob_valid_reg;
    logic [ROB_DEPTH-1:0] rob_valid_next;
    logic [ROB_DEPTH-1:0] rob_done_reg;
    logic [ROB_DEPTH-1:0] rob_done_next;

    logic              out_free;
    logic              ret_any;
    logic              ret_last;
    logic [TAG_W-1:0]  head_adv;
    logic [TAG_W-1:0]  tail_adv;

    // map tag RAM: port 0 serves source 1 and the retire check, port 1 source 2
    logic              map_wr_en;
    logic [AREG_W-1:0] map_wr_addr;
    logic [1:0]        map_rd_en;
    logic [AREG_W-1:0] map_rd_addr [2];
    logic [TAG_W-1:0]  map_rd_data [2];

    logic              dst_wr_en;
    logic [REG_W:0]    dst_rd_data [1];
    logic [TAG_W-1:0]  dst_rd_addr [1];

    logic              ret_dv;
    logic [REG_W-1:0]  ret_dr;
    logic              ret_d_ok;
    logic [AREG_W-1:0] ret_d_idx;

    logic              s1_hit;
    logic              s2_hit;
    logic              dst_ok;
    logic              c_in_live;
    logic [TAG_W-1:0]  c_idx;
    logic              c_ok;
    logic              tail_full;
    logic              cnt_limit;

    logic [EW-1:0]     ent_e;
    logic [RW-1:0]     ret_e;

    rrob_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .func      (req.data.func),
        .out_free  (out_free),
        .ret_any   (ret_any),
        .ret_last  (ret_last),
        .ctl       (ctl)
    );

    assign req.ready = ctl.req_ready;
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = rsp_reg;

    assign out_free = !out_valid_reg || rsp.ready;

    assign head_adv = advance(head_reg, live_reg);
    assign tail_adv = advance(tail_reg, live_reg);

    assign ret_dv    = dst_rd_data[0][REG_W];
    assign ret_dr    = dst_rd_data[0][REG_W-1:0];
    assign ret_d_ok  = AX_W'(ret_dr) < AX_W'(ARCH_REGS);
    assign ret_d_idx = AREG_W'(ret_dr);

    assign ret_any   = rob_valid_reg[head_reg] && rob_done_reg[head_reg];
    assign cnt_limit = (cnt_reg + RCNT_W'(1)) >= lim_reg;
    // stop when the limit is hit, the next head is not retirable or the head would advance onto itself
    assign ret_last  = cnt_limit || !rob_valid_reg[head_adv] || !rob_done_reg[head_adv]
                       || (head_adv == head_reg);

    assign s1_hit = item_reg.src1_valid && (AX_W'(item_reg.src1_reg) < AX_W'(ARCH_REGS))
                    && map_in_rob_reg[AREG_W'(item_reg.src1_reg)];
    assign s2_hit = item_reg.src2_valid && (AX_W'(item_reg.src2_reg) < AX_W'(ARCH_REGS))
                    && map_in_rob_reg[AREG_W'(item_reg.src2_reg)];
    assign dst_ok = AX_W'(item_reg.dst_reg) < AX_W'(ARCH_REGS);

    assign c_in_live = C_W'(item_reg.complete_tag) < C_W'(live_reg);
    assign c_idx     = TAG_W'(item_reg.complete_tag);
    assign c_ok      = c_in_live && rob_valid_reg[c_idx];
    assign tail_full = rob_valid_reg[tail_reg];

    assign map_wr_addr    = AREG_W'(item_reg.dst_reg);
    assign map_rd_en      = {ctl.accept, ctl.accept || ctl.ret_chk_rd};
    assign map_rd_addr[0] = ctl.ret_chk_rd ? ret_d_idx : AREG_W'(req.data.src1_reg);
    assign map_rd_addr[1] = AREG_W'(req.data.src2_reg);
    assign dst_rd_addr[0] = ctl.retire_wr ? head_adv : head_reg;

    rrob_ram #(
        .WIDTH    (TAG_W),
        .DEPTH    (ARCH_REGS),
        .RD_PORTS (2)
    ) u_map_tag (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (tail_reg),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data)
    );

    rrob_ram #(
        .WIDTH    (REG_W + 1),
        .DEPTH    (ROB_DEPTH),
        .RD_PORTS (1)
    ) u_rob_dst (
        .clk     (clk),
        .wr_en   (dst_wr_en),
        .wr_addr (tail_reg),
        .wr_data ({item_reg.dst_valid, item_reg.dst_reg}),
        .rd_en   (ctl.dst_rd),
        .rd_addr (dst_rd_addr),
        .rd_data (dst_rd_data)
    );

    // configuration, clamped once at write time
    assign ent_e = EW'(cfg.data.value[ENTRIES_W-1:0]);
    assign ret_e = RW'(cfg.data.value[RETW_W-1:0]);

    always_comb
    begin
        live_next = live_reg;
        lim_next  = lim_reg;
        if (cfg.valid)
        begin
            if (cfg.data.idx == CFG_ROB_ENTRIES)
            begin
                if (ent_e == '0)
                begin
                    live_next = LIVE_W'(1);
                end
                else if (ent_e > EW'(ROB_DEPTH))
                begin
                    live_next = LIVE_W'(ROB_DEPTH);
                end
                else
                begin
                    live_next = LIVE_W'(ent_e);
                end
            end
            else if (cfg.data.idx == CFG_RETIRE_WIDTH)
            begin
                if (ret_e == '0)
                begin
                    lim_next = RCNT_W'(1);
                end
                else if (ret_e > RW'(MAX_RETIRE))
                begin
                    lim_next = RCNT_W'(MAX_RETIRE);
                end
                else
                begin
                    lim_next = RCNT_W'(ret_e);
                end
            end
        end
    end

    always_comb
    begin
        map_in_rob_next = map_in_rob_reg;
        rob_valid_next  = rob_valid_reg;
        rob_done_next   = rob_done_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cnt_next        = cnt_reg;
        rsp_next        = rsp_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        map_wr_en       = 1'b0;
        dst_wr_en       = 1'b0;

        if (ctl.accept)
        begin
            cnt_next = '0;
        end

        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
            rsp_next       = '0;
            rsp_next.last  = 1'b1;
        end

        if (ctl.rename_wr)
        begin
            if (tail_full)
            begin
                rsp_next.status = STATUS_FULL;
            end
            else
            begin
                rsp_next.src1_in_rob = s1_hit;
                rsp_next.src1_tag    = s1_hit ? TAG_OUT_W'(map_rd_data[0]) : '0;
                rsp_next.src1_avail  = !s1_hit || rob_done_reg[map_rd_data[0]];
                rsp_next.src2_in_rob = s2_hit;
                rsp_next.src2_tag    = s2_hit ? TAG_OUT_W'(map_rd_data[1]) : '0;
                rsp_next.src2_avail  = !s2_hit || rob_done_reg[map_rd_data[1]];
                rsp_next.entry_tag   = TAG_OUT_W'(tail_reg);
                rob_valid_next[tail_reg] = 1'b1;
                rob_done_next[tail_reg]  = 1'b0;
                dst_wr_en = 1'b1;
                if (item_reg.dst_valid && dst_ok)
                begin
                    map_in_rob_next[map_wr_addr] = 1'b1;
                    map_wr_en = 1'b1;
                end
                tail_next = tail_adv;
            end
        end

        if (ctl.complete_wr)
        begin
            if (!c_ok)
            begin
                rsp_next.status = STATUS_BAD_TAG;
            end
            else
            begin
                rob_done_next[c_idx] = 1'b1;
            end
        end

        if (ctl.retire_wr)
        begin
            rsp_next.entry_tag         = TAG_OUT_W'(head_reg);
            rsp_next.retired_valid     = 1'b1;
            rsp_next.retired_dst_valid = ret_dv;
            rsp_next.retired_dst_reg   = ret_dr;
            rsp_next.last              = ret_last;
            // drop the mapping only if no younger rename took the register over
            if (ret_dv && ret_d_ok && map_in_rob_reg[ret_d_idx]
                && (map_rd_data[0] == head_reg))
            begin
                map_in_rob_next[ret_d_idx] = 1'b0;
            end
            rob_valid_next[head_reg] = 1'b0;
            rob_done_next[head_reg]  = 1'b0;
            head_next = head_adv;
            cnt_next  = cnt_reg + RCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg       <= LIVE_W'(LIVE_RST);
            lim_reg        <= RCNT_W'(LIM_RST);
            head_reg       <= '0;
            tail_reg       <= '0;
            cnt_reg        <= '0;
            map_in_rob_reg <= '0;
            rob_valid_reg  <= '0;
            rob_done_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            live_reg       <= live_next;
            lim_reg        <= lim_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            cnt_reg        <= cnt_next;
            map_in_rob_reg <= map_in_rob_next;
            rob_valid_reg  <= rob_valid_next;
            rob_done_reg   <= rob_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            item_reg <= req.data;
        end
        rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire

// ===== rtl/rrob_ram.sv =====
// Generic synchronous RAM: one write port, registered read ports.
`default_nettype none

module rrob_ram #(
    parameter int WIDTH    = 8,
    parameter int DEPTH    = 64,
    parameter int RD_PORTS = 1,
    localparam int AW      = $clog2(DEPTH)
) (
    input  wire                clk,
    input  wire                wr_en,
    input  wire  [AW-1:0]      wr_addr,
    input  wire  [WIDTH-1:0]   wr_data,
    input  wire  [RD_PORTS-1:0] rd_en,
    input  wire  [AW-1:0]      rd_addr [RD_PORTS],
    output logic [WIDTH-1:0]   rd_data [RD_PORTS]
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        for (int i = 0; i < RD_PORTS; i++)
        begin
            if (rd_en[i])
            begin
                rd_data[i] <= mem[rd_addr[i]];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rrob_seq.sv =====
// Sequencer: steps one request through rename, complete, the retire walk or the no-op of an unknown operation.
`default_nettype none

module rrob_seq
    import rrob_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               req_valid,
    input  wire  [FUNC_W-1:0] func,
    input  wire               out_free,
    input  wire               ret_any,
    input  wire               ret_last,
    output rrob_ctl_t         ctl
);

    rrob_state_t state_reg;
    rrob_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (func)
                        FUNC_RENAME:   state_next = ST_RENAME;
                        FUNC_COMPLETE: state_next = ST_COMPLETE;
                        FUNC_RETIRE:   state_next = ST_RET_CHK;
                        default:       state_next = ST_NOP;
                    endcase
                end
            end
            ST_RENAME, ST_COMPLETE, ST_NOP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RET_CHK:
            begin
                if (ret_any)
                begin
                    state_next = ST_RET_UPD;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RET_UPD:
            begin
                if (out_free)
                begin
                    state_next = ret_last ? ST_IDLE : ST_RET_CHK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl = '0;
        ctl.req_ready = (state_reg == ST_IDLE);
        ctl.accept    = ctl.req_ready && req_valid;
        // fetch the head entry's destination at accept in case this is a retire
        ctl.dst_rd    = ctl.accept;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_RENAME:
            begin
                ctl.emit      = out_free;
                ctl.rename_wr = out_free;
            end
            ST_COMPLETE:
            begin
                ctl.emit        = out_free;
                ctl.complete_wr = out_free;
            end
            ST_NOP:
            begin
                ctl.emit = out_free;
            end
            ST_RET_CHK:
            begin
                ctl.ret_chk_rd = ret_any;
                ctl.emit       = !ret_any && out_free;
            end
            ST_RET_UPD:
            begin
                ctl.emit      = out_free;
                ctl.retire_wr = out_free;
                ctl.dst_rd    = out_free && !ret_last;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== test/register_rename_reorder_buffer_tb.sv =====
// Self-checking testbench for the rename map and reorder buffer: directed and random requests.
`timescale 1ns / 100ps

module register_rename_reorder_buffer_tb
    import rrob_pkg::*;
();

    localparam int ROB_SLOTS      = 64;
    localparam int ARCH_REGS_N    = 64;
    localparam int RETIRE_MAX     = 8;
    localparam int PHASES         = 9;
    localparam int ITEMS_PER_PHASE = 21;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

    logic clk;
    logic rst_n = 1'b0;

    rrob_req_if req_ch ();
    rrob_rsp_if rsp_ch ();
    rrob_cfg_if cfg_ch ();

    logic      req_vld = 1'b0;
    rrob_req_t req_dat = '0;
    logic      rsp_rdy = 1'b0;
    logic      cfg_vld = 1'b0;
    rrob_cfg_t cfg_dat = '0;

    assign req_ch.valid = req_vld;
    assign req_ch.data  = req_dat;
    assign rsp_ch.ready = rsp_rdy;
    assign cfg_ch.valid = cfg_vld;
    assign cfg_ch.data  = cfg_dat;

    register_rename_reorder_buffer #(
        .ROB_DEPTH  (ROB_SLOTS),
        .ARCH_REGS  (ARCH_REGS_N),
        .MAX_RETIRE (RETIRE_MAX)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow of the rename map, the buffer and the configuration
    bit             map_in_rob_q [ARCH_REGS_N];
    logic [REG_W-1:0] map_tag_q  [ARCH_REGS_N];
    bit             rob_valid_q  [ROB_SLOTS];
    bit             rob_done_q   [ROB_SLOTS];
    bit             rob_dstv_q   [ROB_SLOTS];
    logic [REG_W-1:0] rob_dst_q  [ROB_SLOTS];
    int             head_q;
    int             tail_q;
    logic [ENTRIES_W-1:0] entries_q = ENTRIES_W'(ENTRIES_RST);
    logic [RETW_W-1:0]    width_q   = RETW_W'(RETW_RST);

    rrob_req_t pending_reqs [$];
    rrob_rsp_t expected_rsps [$];
    int        error_count = 0;
    int        send_idle_pct = 20;
    int        recv_idle_pct = 59;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int live_slots();
        if (entries_q == 0)
            return 1;
        if (entries_q > ROB_SLOTS)
            return ROB_SLOTS;
        return int'(entries_q);
    endfunction

    function automatic int next_slot(input int p);
        return (p + 1 >= live_slots()) ? 0 : p + 1;
    endfunction

    // Returns {in_rob, tag, avail} for one source operand
    function automatic logic [7:0] lookup_source(input logic present, input logic [REG_W-1:0] areg);
        logic [7:0] res;
        res = {1'b0, 6'd0, 1'b1};
        if (present && map_in_rob_q[areg])
            res = {1'b1, map_tag_q[areg], rob_done_q[map_tag_q[areg]]};
        return res;
    endfunction

    task automatic predict_request(input rrob_req_t r);
        rrob_rsp_t o;
        int t;
        int h;
        int lim;
        int k;
        bit have;
        o = '0;
        o.last = 1'b1;
        case (r.func)
            FUNC_RENAME:
            begin
                t = tail_q;
                if (rob_valid_q[t])
                    o.status = STATUS_FULL;
                else
                begin
                    {o.src1_in_rob, o.src1_tag, o.src1_avail} =
                        lookup_source(r.src1_valid, r.src1_reg);
                    {o.src2_in_rob, o.src2_tag, o.src2_avail} =
                        lookup_source(r.src2_valid, r.src2_reg);
                    rob_valid_q[t] = 1'b1;
                    rob_done_q[t]  = 1'b0;
                    rob_dstv_q[t]  = r.dst_valid;
                    rob_dst_q[t]   = r.dst_reg;
                    if (r.dst_valid)
                    begin
                        map_in_rob_q[r.dst_reg] = 1'b1;
                        map_tag_q[r.dst_reg]    = 6'(t);
                    end
                    o.entry_tag = 6'(t);
                    tail_q = next_slot(t);
                end
                expected_rsps.push_back(o);
            end
            FUNC_COMPLETE:
            begin
                t = int'(r.complete_tag);
                if (t >= live_slots() || !rob_valid_q[t])
                    o.status = STATUS_BAD_TAG;
                else
                    rob_done_q[t] = 1'b1;
                expected_rsps.push_back(o);
            end
            FUNC_RETIRE:
            begin
                lim = int'(width_q);
                if (lim == 0)
                    lim = 1;
                if (lim > RETIRE_MAX)
                    lim = RETIRE_MAX;
                have = 1'b0;
                for (k = 0; k < lim; k++)
                begin
                    h = head_q;
                    if (!(rob_valid_q[h] && rob_done_q[h]))
                        break;
                    if (rob_dstv_q[h] && map_in_rob_q[rob_dst_q[h]]
                        && map_tag_q[rob_dst_q[h]] == 6'(h))
                        map_in_rob_q[rob_dst_q[h]] = 1'b0;
                    rob_valid_q[h] = 1'b0;
                    rob_done_q[h]  = 1'b0;
                    // hold each entry back until we know whether it is the last one
                    if (have)
                        expected_rsps.push_back(o);
                    o = '0;
                    o.entry_tag         = 6'(h);
                    o.retired_valid     = 1'b1;
                    o.retired_dst_valid = rob_dstv_q[h];
                    o.retired_dst_reg   = rob_dst_q[h];
                    have = 1'b1;
                    head_q = next_slot(h);
                end
                o.last = 1'b1;
                expected_rsps.push_back(o);
            end
            default:
                expected_rsps.push_back(o);
        endcase
    endtask

    task automatic report_error(input string what, input int got_v, input int want_v);
        $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got_v, want_v);
        error_count++;
    endtask

    task automatic check_response(input rrob_rsp_t got);
        rrob_rsp_t want;
        if (expected_rsps.size() == 0)
        begin
            report_error("response with nothing pending, entry_tag", int'(got.entry_tag), -1);
            return;
        end
        want = expected_rsps.pop_front();
        if (got.status != want.status)
            report_error("status", int'(got.status), int'(want.status));
        if (got.src1_in_rob != want.src1_in_rob)
            report_error("src1_in_rob", int'(got.src1_in_rob), int'(want.src1_in_rob));
        if (got.src1_tag != want.src1_tag)
            report_error("src1_tag", int'(got.src1_tag), int'(want.src1_tag));
        if (got.src1_avail != want.src1_avail)
            report_error("src1_avail", int'(got.src1_avail), int'(want.src1_avail));
        if (got.src2_in_rob != want.src2_in_rob)
            report_error("src2_in_rob", int'(got.src2_in_rob), int'(want.src2_in_rob));
        if (got.src2_tag != want.src2_tag)
            report_error("src2_tag", int'(got.src2_tag), int'(want.src2_tag));
        if (got.src2_avail != want.src2_avail)
            report_error("src2_avail", int'(got.src2_avail), int'(want.src2_avail));
        if (got.entry_tag != want.entry_tag)
            report_error("entry_tag", int'(got.entry_tag), int'(want.entry_tag));
        if (got.retired_valid != want.retired_valid)
            report_error("retired_valid", int'(got.retired_valid), int'(want.retired_valid));
        if (got.retired_dst_valid != want.retired_dst_valid)
            report_error("retired_dst_valid", int'(got.retired_dst_valid),
                         int'(want.retired_dst_valid));
        if (got.retired_dst_reg != want.retired_dst_reg)
            report_error("retired_dst_reg", int'(got.retired_dst_reg),
                         int'(want.retired_dst_reg));
        if (got.last != want.last)
            report_error("last", int'(got.last), int'(want.last));
    endtask

    // Request driver: predict on accept, then offer the next request or idle
    always @(posedge clk)
    begin
        if (!rst_n)
            req_vld <= 1'b0;
        else
        begin
            if (req_vld && req_ch.ready)
                predict_request(req_dat);
            if (!req_vld || req_ch.ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_dat <= pending_reqs.pop_front();
                    req_vld <= 1'b1;
                end
                else
                    req_vld <= 1'b0;
            end
        end
    end

    // Response monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_rdy <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_rdy)
                check_response(rsp_ch.data);
            rsp_rdy <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_vld && req_ch.ready) || (rsp_ch.valid && rsp_rdy))
                stalled = 0;
            else
                stalled++;
        end
        $display("register_rename_reorder_buffer_tb: errors");
        $finish;
    end

    function automatic rrob_req_t rename_req(input int s1v, input int s1, input int s2v,
                                             input int s2, input int dv, input int d);
        rrob_req_t r;
        r = '0;
        r.func       = FUNC_RENAME;
        r.src1_valid = 1'(s1v);
        r.src1_reg   = 6'(s1);
        r.src2_valid = 1'(s2v);
        r.src2_reg   = 6'(s2);
        r.dst_valid  = 1'(dv);
        r.dst_reg    = 6'(d);
        return r;
    endfunction

    function automatic rrob_req_t complete_req(input int tag);
        rrob_req_t r;
        r = '0;
        r.func         = FUNC_COMPLETE;
        r.complete_tag = 6'(tag);
        return r;
    endfunction

    function automatic rrob_req_t retire_req();
        rrob_req_t r;
        r = '0;
        r.func = FUNC_RETIRE;
        return r;
    endfunction

    function automatic rrob_req_t random_request();
        rrob_req_t r;
        bit [31:0] raw;
        int pick;
        int open_tags [$];
        int k;
        raw = $urandom;
        r = raw[$bits(rrob_req_t)-1:0];
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            // keep most registers in a small set so lookups hit in-flight entries
            r.func       = FUNC_RENAME;
            r.src1_valid = ($urandom_range(9) < 8);
            r.src2_valid = ($urandom_range(9) < 8);
            r.dst_valid  = ($urandom_range(9) < 8);
            if ($urandom_range(3) != 0)
                r.src1_reg = 6'($urandom_range(7));
            if ($urandom_range(3) != 0)
                r.src2_reg = 6'($urandom_range(7));
            if ($urandom_range(3) != 0)
                r.dst_reg = 6'($urandom_range(7));
        end
        else if (pick < 75)
        begin
            r.func = FUNC_COMPLETE;
            for (k = 0; k < ROB_SLOTS; k++)
                if (rob_valid_q[k] && !rob_done_q[k])
                    open_tags.push_back(k);
            if (open_tags.size() != 0 && $urandom_range(9) < 8)
                r.complete_tag = 6'(open_tags[$urandom_range(open_tags.size() - 1)]);
        end
        else if (pick < 95)
            r.func = FUNC_RETIRE;
        else
            r.func = FUNC_UNKNOWN;
        return r;
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_vld || expected_rsps.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int value);
        rrob_cfg_t w;
        w.idx   = idx;
        w.value = 7'(value);
        @(posedge clk);
        cfg_vld <= 1'b1;
        cfg_dat <= w;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == CFG_ROB_ENTRIES)
            entries_q = w.value;
        else if (idx == CFG_RETIRE_WIDTH)
            width_q = w.value[RETW_W-1:0];
        cfg_vld <= 1'b0;
    endtask

    initial
    begin
        int phase_entries [PHASES];
        int phase_width   [PHASES];
        rrob_req_t r;
        int p;
        int k;
        phase_entries = '{4, 0, 127, 7, 64, 1, 16, 3, 64};
        phase_width   = '{2, 0, 15, 1, 8, 3, 4, 127, 4};
        for (k = 0; k < ARCH_REGS_N; k++)
        begin
            map_in_rob_q[k] = 1'b0;
            map_tag_q[k]    = '0;
        end
        for (k = 0; k < ROB_SLOTS; k++)
        begin
            rob_valid_q[k] = 1'b0;
            rob_done_q[k]  = 1'b0;
            rob_dstv_q[k]  = 1'b0;
            rob_dst_q[k]   = '0;
        end
        head_q = 0;
        tail_q = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset configuration
        pending_reqs.push_back(retire_req());                      // nothing to retire
        pending_reqs.push_back(rename_req(1, 0, 1, 63, 1, 5));     // sources architectural
        pending_reqs.push_back(rename_req(1, 5, 0, 5, 0, 63));     // no destination
        pending_reqs.push_back(rename_req(1, 5, 1, 5, 1, 5));      // remap r5
        pending_reqs.push_back(complete_req(0));
        pending_reqs.push_back(complete_req(0));                   // already done
        pending_reqs.push_back(complete_req(63));                  // entry not valid
        pending_reqs.push_back(rename_req(1, 5, 1, 63, 1, 63));
        pending_reqs.push_back(complete_req(2));
        pending_reqs.push_back(complete_req(1));
        pending_reqs.push_back(rename_req(1, 5, 1, 63, 0, 0));     // one ready, one waiting
        pending_reqs.push_back(retire_req());                      // stops at a waiting entry
        pending_reqs.push_back(rename_req(1, 5, 1, 63, 1, 0));
        r = '1;
        r.func = FUNC_UNKNOWN;
        pending_reqs.push_back(r);
        pending_reqs.push_back(complete_req(3));
        pending_reqs.push_back(complete_req(4));
        pending_reqs.push_back(complete_req(5));
        pending_reqs.push_back(retire_req());
        pending_reqs.push_back(rename_req(1, 63, 1, 63, 1, 63));   // all ones
        pending_reqs.push_back(complete_req(0));                   // freed entry
        pending_reqs.push_back('0);                                // all zeros rename
        wait_drained();

        // Random part: resize without flushing between phases
        for (p = 0; p < PHASES; p++)
        begin
            if (p == 3)
            begin
                send_idle_pct = 59;
                recv_idle_pct = 20;
            end
            else if (p == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_cfg(CFG_ROB_ENTRIES, phase_entries[p]);
            write_cfg(CFG_RETIRE_WIDTH, phase_width[p]);
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                @(negedge clk);
                while (pending_reqs.size() >= 2)
                    @(negedge clk);
                pending_reqs.push_back(random_request());
                // hold the sender until the block has emptied its result stream
                if (p == 4 && k == ITEMS_PER_PHASE / 2)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (20) @(negedge clk);
        if (error_count == 0)
            $display("register_rename_reorder_buffer_tb: clean");
        else
            $display("register_rename_reorder_buffer_tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rrob_pkg.sv
rtl/rrob_ifs.sv
rtl/rrob_ram.sv
rtl/rrob_seq.sv
rtl/register_rename_reorder_buffer.sv
test/register_rename_reorder_buffer_tb.sv
